### rtl/lckc_pkg.sv
//------------------------------------------------------------------------------
// lckc_pkg
// Shared types, constants and lookup functions of the LED chaser key controller.
//------------------------------------------------------------------------------
`default_nettype none

package lckc_pkg;

	localparam int LED_COUNT   = 8;
	localparam int COUNT_LIMIT = 99;

	localparam int POS_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int CNT_W    = $clog2(COUNT_LIMIT + 1);
	localparam int LED_W    = 8;
	localparam int PERIOD_W = 10;
	localparam int KEYT_W   = 8;
	localparam int DIGIT_W  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	// reciprocal for divide by ten, exact for values up to 1028
	localparam int DIV10_MUL   = 205;
	localparam int DIV10_SHIFT = 11;
	localparam int DIV10_PW    = CNT_W + 8;

	localparam logic [DIGIT_W-1:0] CODE_C = 4'hC;
	localparam logic [DIGIT_W-1:0] CODE_A = 4'hA;
	localparam logic [DIGIT_W-1:0] CODE_0 = 4'h0;
	localparam logic [DIGIT_W-1:0] CODE_5 = 4'h5;

	localparam logic [1:0] SPEED_ONE   = 2'd1;
	localparam logic [1:0] SPEED_TWO   = 2'd2;
	localparam logic [1:0] SPEED_THREE = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_ONE   = 3'd0,
		REG_PERIOD_TWO   = 3'd1,
		REG_PERIOD_THREE = 3'd2,
		REG_STATUS_HOLD  = 3'd3,
		REG_DEBOUNCE     = 3'd4,
		REG_PRESS_STEP   = 3'd5,
		REG_LONG_STEPS   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_DEBOUNCE = 2'd1,
		PH_PRESS    = 2'd2,
		PH_HELD     = 2'd3
	} key_phase_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_one;
		logic [PERIOD_W-1:0] period_two;
		logic [PERIOD_W-1:0] period_three;
		logic [PERIOD_W-1:0] status_hold;
		logic [KEYT_W-1:0]   debounce;
		logic [KEYT_W-1:0]   press_step;
		logic [KEYT_W-1:0]   long_steps;
	} cfg_t;

	typedef struct packed {
		logic set_changing;
		logic short_release;
		logic long_release;
		logic show_speed;
	} key_act_t;

	typedef struct packed {
		logic [1:0]       speed_now;
		logic             running;
		logic [1:0]       digit_select;
		logic [7:0]       segments;
		logic [LED_W-1:0] led_bar_n;
	} result_t;

	function automatic logic [7:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [7:0] p;
		unique case (d)
			4'h0: p = 8'h3F;
			4'h1: p = 8'h06;
			4'h2: p = 8'h5B;
			4'h3: p = 8'h4F;
			4'h4: p = 8'h66;
			4'h5: p = 8'h6D;
			4'h6: p = 8'h7D;
			4'h7: p = 8'h07;
			4'h8: p = 8'h7F;
			4'h9: p = 8'h6F;
			4'hA: p = 8'h77;
			4'hB: p = 8'h7C;
			4'hC: p = 8'h39;
			4'hD: p = 8'h5E;
			4'hE: p = 8'h79;
			default: p = 8'h71;
		endcase
		return p;
	endfunction

	function automatic logic [2*DIGIT_W-1:0] to_bcd(input logic [CNT_W-1:0] v);
		logic [DIV10_PW-1:0] prod;
		logic [DIGIT_W-1:0]  tens;
		logic [CNT_W-1:0]    ones;
		prod = DIV10_PW'(v) * DIV10_PW'(DIV10_MUL);
		tens = DIGIT_W'(prod >> DIV10_SHIFT);
		ones = v - CNT_W'(tens) * CNT_W'(10);
		return {tens, ones[DIGIT_W-1:0]};
	endfunction

endpackage

`default_nettype wire

### rtl/lckc_cfg_regs.sv
//------------------------------------------------------------------------------
// lckc_cfg_regs
// Write-only configuration registers with their reset values.
//------------------------------------------------------------------------------
`default_nettype none

module lckc_cfg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [lckc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [lckc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output lckc_pkg::cfg_t                 cfg
);
	import lckc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_one   <= PERIOD_W'(500);
			cfg_q.period_two   <= PERIOD_W'(300);
			cfg_q.period_three <= PERIOD_W'(150);
			cfg_q.status_hold  <= PERIOD_W'(500);
			cfg_q.debounce     <= KEYT_W'(20);
			cfg_q.press_step   <= KEYT_W'(10);
			cfg_q.long_steps   <= KEYT_W'(50);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PERIOD_ONE:   cfg_q.period_one   <= cfg_wdata[PERIOD_W-1:0];
				REG_PERIOD_TWO:   cfg_q.period_two   <= cfg_wdata[PERIOD_W-1:0];
				REG_PERIOD_THREE: cfg_q.period_three <= cfg_wdata[PERIOD_W-1:0];
				REG_STATUS_HOLD:  cfg_q.status_hold  <= cfg_wdata[PERIOD_W-1:0];
				REG_DEBOUNCE:     cfg_q.debounce     <= cfg_wdata[KEYT_W-1:0];
				REG_PRESS_STEP:   cfg_q.press_step   <= cfg_wdata[KEYT_W-1:0];
				REG_LONG_STEPS:   cfg_q.long_steps   <= cfg_wdata[KEYT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### rtl/lckc_key_fsm.sv
//------------------------------------------------------------------------------
// lckc_key_fsm
// Key debounce and press-length classifier, one step per tick.
//------------------------------------------------------------------------------
`default_nettype none

module lckc_key_fsm (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step_en,
	input  wire                 pressed,
	input  lckc_pkg::cfg_t      cfg,
	output lckc_pkg::key_act_t  act
);
	import lckc_pkg::*;

	key_phase_t        phase_q, phase_d;
	logic [KEYT_W-1:0] timer_q, timer_d;
	logic [KEYT_W-1:0] steps_q, steps_d;
	logic [KEYT_W-1:0] timer_inc, steps_inc;
	logic              deb_done, step_done;

	assign timer_inc = (timer_q == '1) ? timer_q : timer_q + KEYT_W'(1);
	assign steps_inc = (steps_q == '1) ? steps_q : steps_q + KEYT_W'(1);
	assign deb_done  = (timer_inc >= cfg.debounce);
	assign step_done = (timer_inc >= cfg.press_step);

	// next state
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		steps_d = steps_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					phase_d = PH_DEBOUNCE;
					timer_d = '0;
					steps_d = '0;
				end
			end
			PH_DEBOUNCE: begin
				timer_d = timer_inc;
				if (deb_done) begin
					timer_d = '0;
					phase_d = pressed ? PH_PRESS : PH_IDLE;
				end
			end
			PH_PRESS: begin
				timer_d = timer_inc;
				if (step_done) begin
					timer_d = '0;
					steps_d = steps_inc;
					if (!pressed) begin
						phase_d = PH_IDLE;
					end else if (steps_inc >= cfg.long_steps) begin
						phase_d = PH_HELD;
					end
				end
			end
			PH_HELD: begin
				if (!pressed) begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		act = '0;
		unique case (phase_q)
			PH_IDLE: ;
			PH_DEBOUNCE: begin
				act.set_changing = deb_done && pressed;
			end
			PH_PRESS: begin
				if (step_done) begin
					if (!pressed) begin
						act.short_release = (steps_inc < cfg.long_steps);
						act.long_release  = (steps_inc >= cfg.long_steps);
					end else begin
						act.show_speed = (steps_inc >= cfg.long_steps);
					end
				end
			end
			PH_HELD: begin
				act.long_release = !pressed;
				act.show_speed   = pressed;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			steps_q <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			steps_q <= steps_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({act.short_release, act.long_release, act.show_speed, act.set_changing}))
		else $error("key actions overlap");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && phase_q == PH_IDLE && pressed) |=> (phase_q == PH_DEBOUNCE && timer_q == '0))
		else $error("press did not start debounce");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && act.show_speed) |=> (phase_q == PH_HELD))
		else $error("speed shown outside held phase");

endmodule

`default_nettype wire

### rtl/lckc_core.sv
//------------------------------------------------------------------------------
// lckc_core
// Per-tick timer work: digit multiplexing, status hold, LED chaser, counter and key actions.
//------------------------------------------------------------------------------
`default_nettype none

module lckc_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step_en,
	input  lckc_pkg::cfg_t      cfg,
	input  lckc_pkg::key_act_t  act,
	output lckc_pkg::result_t   res
);
	import lckc_pkg::*;

	logic                run_q, run_d;
	logic                status_q, status_d;
	logic [PERIOD_W-1:0] status_ticks_q, status_ticks_d;
	logic                changing_q, changing_d;
	logic [1:0]          speed_q, speed_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic                first_q, first_d;
	logic [PERIOD_W-1:0] led_ticks_q, led_ticks_d;
	logic [DIGIT_W-1:0]  digit_q [2];
	logic [DIGIT_W-1:0]  digit_d [2];
	logic                cursor_q;
	logic [LED_W-1:0]    latch_q, latch_d;

	logic [PERIOD_W-1:0] st_inc, led_inc, period;
	logic                status_live, chase_en, fire, show;
	logic [DIGIT_W-1:0]  code_l, code_r;
	logic [2*DIGIT_W-1:0] bcd;

	always_comb begin
		unique case (speed_q)
			SPEED_TWO:   period = cfg.period_two;
			SPEED_THREE: period = cfg.period_three;
			default:     period = cfg.period_one;
		endcase
	end

	assign st_inc  = (status_ticks_q == '1) ? status_ticks_q : status_ticks_q + PERIOD_W'(1);
	assign led_inc = (led_ticks_q == '1) ? led_ticks_q : led_ticks_q + PERIOD_W'(1);

	always_comb begin
		// status hold timer
		status_live    = status_q;
		status_ticks_d = status_ticks_q;
		if (status_q) begin
			status_ticks_d = st_inc;
			if (st_inc >= cfg.status_hold) begin
				status_live = 1'b0;
			end
		end

		// chaser
		chase_en    = run_q && !status_live && !changing_q;
		fire        = chase_en && (led_inc >= period);
		led_ticks_d = led_ticks_q;
		pos_d       = pos_q;
		count_d     = count_q;
		first_d     = first_q;
		latch_d     = latch_q;
		if (chase_en) begin
			led_ticks_d = led_inc;
		end
		if (fire) begin
			led_ticks_d = '0;
			if (first_q) begin
				pos_d   = '0;
				count_d = CNT_W'(1);
				first_d = 1'b0;
			end else begin
				pos_d   = (pos_q == POS_W'(LED_COUNT - 1)) ? '0 : pos_q + POS_W'(1);
				count_d = (count_q == CNT_W'(COUNT_LIMIT)) ? '0 : count_q + CNT_W'(1);
			end
			latch_d = ~(LED_W'(1) << pos_d);
		end

		// key results
		run_d      = run_q;
		speed_d    = speed_q;
		changing_d = changing_q;
		if (act.set_changing) begin
			changing_d = 1'b1;
		end
		if (act.short_release) begin
			changing_d = 1'b0;
			run_d      = !run_q;
		end
		if (act.long_release) begin
			changing_d = 1'b0;
			run_d      = 1'b1;
			speed_d    = (speed_q == SPEED_THREE) ? SPEED_ONE : speed_q + 2'd1;
		end

		show   = act.short_release || act.long_release || act.show_speed;
		code_r = CODE_A;
		if (act.short_release) begin
			code_l = run_d ? CODE_C : CODE_0;
			code_r = run_d ? CODE_A : CODE_5;
		end else begin
			code_l = DIGIT_W'(speed_d);
		end

		status_d = show ? 1'b1 : status_live;
		if (show) begin
			status_ticks_d = '0;
		end

		// digits
		bcd        = to_bcd(count_d);
		digit_d[0] = digit_q[0];
		digit_d[1] = digit_q[1];
		if (!status_d && !changing_d) begin
			digit_d[0] = bcd[DIGIT_W-1:0];
			digit_d[1] = bcd[2*DIGIT_W-1:DIGIT_W];
		end else if (show) begin
			digit_d[0] = code_l;
			digit_d[1] = code_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q          <= 1'b0;
			status_q       <= 1'b0;
			status_ticks_q <= '0;
			changing_q     <= 1'b0;
			speed_q        <= SPEED_TWO;
			pos_q          <= '0;
			count_q        <= '0;
			first_q        <= 1'b1;
			led_ticks_q    <= '0;
			digit_q[0]     <= '0;
			digit_q[1]     <= '0;
			cursor_q       <= 1'b0;
			latch_q        <= '1;
		end else if (step_en) begin
			run_q          <= run_d;
			status_q       <= status_d;
			status_ticks_q <= status_ticks_d;
			changing_q     <= changing_d;
			speed_q        <= speed_d;
			pos_q          <= pos_d;
			count_q        <= count_d;
			first_q        <= first_d;
			led_ticks_q    <= led_ticks_d;
			digit_q[0]     <= digit_d[0];
			digit_q[1]     <= digit_d[1];
			cursor_q       <= !cursor_q;
			latch_q        <= latch_d;
		end
	end

	always_comb begin
		res.led_bar_n    = latch_d;
		res.segments     = seg_pattern(digit_q[cursor_q]);
		res.digit_select = cursor_q ? 2'b10 : 2'b01;
		res.running      = run_d;
		res.speed_now    = speed_d;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> (cursor_q != $past(cursor_q)))
		else $error("digit cursor did not alternate");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && act.long_release) |=> (run_q && status_q && !changing_q))
		else $error("speed change did not start running with status");

	assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> ($stable(latch_q) && $stable(count_q) && $stable(speed_q)))
		else $error("state moved without a tick");

	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q <= CNT_W'(COUNT_LIMIT)) && (speed_q != 2'd0))
		else $error("counter or speed out of range");

endmodule

`default_nettype wire

### rtl/led_chaser_key_controller_top.sv
//------------------------------------------------------------------------------
// led_chaser_key_controller_top
// LED chaser with single-key control and two-digit multiplexed display.
//------------------------------------------------------------------------------
// Each input transaction is one 1 ms tick carrying the sampled key level; each
// tick yields exactly one output transaction with the LED bar, the driven digit
// and the run/speed status. A tick is taken into an input register, processed
// in one pass of logic and captured in the output register when the output
// side can advance, and a new tick is accepted every cycle as long as the
// output side keeps up. Configuration writes take effect on the next tick
// processed.
`default_nettype none

module led_chaser_key_controller_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [7:0]                     s_axis_tdata,  // [0] key_level
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// [7:0] led_bar_n, [15:8] segments, [17:16] digit_select,
	// [18] running, [20:19] speed_now
	output logic [23:0]                    m_axis_tdata,
	input  wire                            cfg_we,
	input  wire  [lckc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [lckc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lckc_pkg::*;

	cfg_t     cfg;
	key_act_t act;
	result_t  res;

	logic    valid_s1, key_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    adv, step_en, in_acc;

	assign adv           = !valid_s2 || m_axis_tready;
	assign step_en       = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (step_en) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_s1 <= s_axis_tdata[0];
		end
		if (step_en) begin
			result_s2 <= res;
		end
	end

	lckc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	lckc_key_fsm u_key (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.pressed (!key_s1),
		.cfg     (cfg),
		.act     (act)
	);

	lckc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.cfg     (cfg),
		.act     (act),
		.res     (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, result_s2};

endmodule

`default_nettype wire
